// File: rtl/ising_spin_annealing_step_defines.svh
// Assertion macros used by the annealer RTL.
// Both macros sample on the rising edge of clk and are off while arst_n is low.
`ifndef ISING_SPIN_ANNEALING_STEP_DEFINES_SVH
`define ISING_SPIN_ANNEALING_STEP_DEFINES_SVH

// Same-cycle implication.
`define ISA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ISA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/isa_pkg.sv
`timescale 1ns / 1ps
package isa_pkg;

	localparam int NUM_QUBITS_DEF      = 128;
	localparam int NUM_COUPLINGS_DEF   = 256;
	localparam int EXP_TABLE_DEPTH_DEF = 4096;

	// exp(-1/256) in Q0.32, the ratio between neighboring table entries.
	localparam logic [31:0] EXP_STEP_Q32 = 32'd4278222805;

	localparam int E_W     = 18;
	localparam int E_MAX_I = 131071;
	localparam int E_MIN_I = -131072;

	localparam logic [31:0] INIT_TEMP_RST = 32'd5153961;
	localparam logic [31:0] COOL_RST      = 32'd4294954411;
	localparam logic [31:0] FLAT_COOL_RST = 32'd4294965455;
	localparam logic [13:0] OFFSET_RST    = 14'd1024;
	localparam logic [13:0] HIDDEN_RST    = 14'd512;

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_SPIN  = 2'd1,
		CMD_START = 2'd2,
		CMD_STEP  = 2'd3
	} cmd_e_t;

	typedef enum logic [2:0] {
		REG_INIT_TEMP = 3'd0,
		REG_COOL      = 3'd1,
		REG_FLAT_COOL = 3'd2,
		REG_OFFSET    = 3'd3,
		REG_HIDDEN    = 3'd4
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_SUM,
		ST_EVAL,
		ST_MUL,
		ST_DIVSET,
		ST_DIV,
		ST_ROM,
		ST_DECIDE,
		ST_COOL,
		ST_COMMIT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [6:0]        qa;
		logic [6:0]        qb;
		logic signed [7:0] w;
	} coupling_t;

endpackage

// File: rtl/ising_spin_annealing_step.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake              Beat contents
// in        input      in_valid / in_stall    cmd, coupling_slot, qubit_a, qubit_b, weight,
//                                             spin_up, flip_qubit, uniform
// out       output     out_valid / out_stall  accepted, current_energy, best_energy,
//                                             temperature, range_error
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Load, set-spin and start commands go from idle straight to the done state, which moves
// their result into the output register. In an anneal step the energy sum walks the
// coupling memory one entry per cycle, and the Metropolis ratio comes from a restoring
// divider that yields one quotient bit a cycle. After reset the block builds the exp
// table, one entry per cycle, and holds in_stall high meanwhile; configuration writes
// are taken at any time. A result waits in the output register while out_stall is
// high; the next input beat is taken once the block is back in idle.
`include "ising_spin_annealing_step_defines.svh"
module ising_spin_annealing_step
	import isa_pkg::*;
#(
	parameter int NUM_QUBITS      = NUM_QUBITS_DEF,
	parameter int NUM_COUPLINGS   = NUM_COUPLINGS_DEF,
	parameter int EXP_TABLE_DEPTH = EXP_TABLE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         cmd,
	input  logic [7:0]         coupling_slot,
	input  logic [6:0]         qubit_a,
	input  logic [6:0]         qubit_b,
	input  logic signed [7:0]  weight,
	input  logic               spin_up,
	input  logic [6:0]         flip_qubit,
	input  logic [15:0]        uniform,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               accepted,
	output logic signed [17:0] current_energy,
	output logic signed [17:0] best_energy,
	output logic [31:0]        temperature,
	output logic               range_error,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	localparam int QW = (NUM_QUBITS > 1) ? $clog2(NUM_QUBITS) : 1;
	localparam int CW = (NUM_COUPLINGS > 1) ? $clog2(NUM_COUPLINGS) : 1;
	localparam int XW = $clog2(EXP_TABLE_DEPTH);
	localparam int QB = XW + 1;
	// Accumulator: offset plus up to NUM_COUPLINGS terms of magnitude 128.
	localparam int AW = ((CW + 8 > 15) ? CW + 8 : 15) + 4;
	// Divider: numerator dH * 2^40 needs 58 bits, shifted divisor 49 + QB bits.
	localparam int RW = (49 + QB > 59) ? 49 + QB : 59;
	localparam logic signed [AW-1:0] ACC_HI = AW'(E_MAX_I);
	localparam logic signed [AW-1:0] ACC_LO = AW'(E_MIN_I);

	state_t state_q, state_d;

	// Configuration registers.
	logic [31:0] init_temp_q, cool_q, flat_cool_q;
	logic [13:0] offset_q, hidden_q;

	// Architectural state.
	logic signed [17:0] e_now_q, e_best_q;
	logic [31:0]        temp_q;

	// Stores.
	coupling_t coup_mem [NUM_COUPLINGS];
	logic      spin_mem [NUM_QUBITS];
	logic [15:0] exp_mem [EXP_TABLE_DEPTH];

	// Item latched at the input beat, with the step's decision and the flipped qubit's old spin.
	logic [6:0]  fq_q;
	logic [15:0] uni_q;
	logic        err_q, acc_q, old_spin_q;

	// Energy sum pipeline.
	logic [CW:0]        k_q;
	logic               v_s1, v_s2;
	coupling_t          coup_s1;
	logic               spin_a_s2, spin_b_s2, fa_s2, fb_s2;
	logic signed [7:0]  w_s2;
	logic signed [AW-1:0] sum_q;

	// Metropolis evaluation.
	logic signed [17:0] hnew_q;
	logic signed [18:0] dh_q;
	logic [48:0]        den_q;
	logic [RW-1:0]      rem_q, dsh_q;
	logic [QB-1:0]      qt_q;
	logic [$clog2(QB+1)-1:0] dcnt_q;
	logic               sat_q, flat_q;
	logic [15:0]        exp_rd_q;

	// Exp table build.
	logic [32:0] r_q;
	logic [XW:0] ia_q;

	// Output register.
	logic               out_valid_q, acc_out_q, err_out_q;
	logic signed [17:0] cur_out_q, best_out_q;
	logic [31:0]        temp_out_q;
	logic               out_load;

	// Memory port controls.
	logic          coup_we, spin_we, spin_wd;
	logic [QW-1:0] spin_wa, spin_ra;

	logic               in_fire, sum_issue, ge, qfit;
	logic signed [17:0] hnew_c;
	logic signed [18:0] dh_c;
	logic [64:0]        r_prod;
	logic [33:0]        r_round;
	logic [15:0]        rom_val;
	logic [63:0]        cool_prod;
	logic [15:0]        thr;
	logic               step_err, load_err, spin_err;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_fire   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign sum_issue = (state_q == ST_SUM) && (k_q < (CW+1)'(NUM_COUPLINGS));
	// The output register takes a new beat once it is empty or being drained.
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	assign load_err = (32'(coupling_slot) >= NUM_COUPLINGS) || (32'(qubit_a) >= NUM_QUBITS)
		|| (32'(qubit_b) >= NUM_QUBITS);
	assign spin_err = (32'(qubit_a) >= NUM_QUBITS);
	assign step_err = (32'(flip_qubit) >= NUM_QUBITS);

	// Saturated new energy and its difference from the current energy.
	always_comb begin
		if (sum_q > ACC_HI) begin
			hnew_c = 18'(E_MAX_I);
		end else if (sum_q < ACC_LO) begin
			hnew_c = 18'(E_MIN_I);
		end else begin
			hnew_c = sum_q[17:0];
		end
		dh_c = {hnew_c[17], hnew_c} - {e_now_q[17], e_now_q};
	end

	assign ge        = (rem_q >= dsh_q);
	assign qfit      = (32'(qt_q) < EXP_TABLE_DEPTH);
	assign thr       = sat_q ? 16'd0 : exp_rd_q;
	assign cool_prod = temp_q * (flat_q ? flat_cool_q : cool_q);

	// Table entry: round r to Q0.16 and clip to 16 bits.
	assign r_prod  = r_q * EXP_STEP_Q32;
	assign r_round = {1'b0, r_q} + 34'd32768;
	assign rom_val = (r_round[33:16] > 18'd65535) ? 16'hFFFF : r_round[31:16];

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT: begin
				if (ia_q == (XW+1)'(EXP_TABLE_DEPTH - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_fire) begin
					if (cmd == CMD_STEP && !step_err) state_d = ST_SUM;
					else state_d = ST_DONE;
				end
			end
			ST_SUM: begin
				if (!sum_issue && !v_s1 && !v_s2) state_d = ST_EVAL;
			end
			ST_EVAL: state_d = ST_MUL;
			ST_MUL: begin
				if (dh_q < 0) state_d = ST_COOL;
				else if (e_now_q <= 0) state_d = (dh_q == 0) ? ST_COOL : ST_COMMIT;
				else state_d = ST_DIVSET;
			end
			ST_DIVSET: state_d = (den_q == '0) ? ST_DECIDE : ST_DIV;
			ST_DIV: begin
				if (dcnt_q == ($clog2(QB+1))'(QB) && ge) state_d = ST_DECIDE;
				else if (dcnt_q == '0) state_d = ST_ROM;
			end
			ST_ROM: state_d = ST_DECIDE;
			ST_DECIDE: state_d = (thr > uni_q && dh_q == 0) ? ST_COOL : ST_COMMIT;
			ST_COOL: state_d = ST_COMMIT;
			ST_COMMIT: state_d = ST_DONE;
			ST_DONE: begin
				if (!out_valid_q || !out_stall) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Memory port controls.
	always_comb begin
		coup_we = 1'b0;
		spin_we = 1'b0;
		spin_wa = QW'(qubit_a);
		spin_wd = spin_up;
		spin_ra = QW'(coup_s1.qa);
		unique case (state_q)
			ST_IDLE: begin
				spin_ra = QW'(flip_qubit);
				coup_we = in_fire && (cmd == CMD_LOAD) && !load_err;
				spin_we = in_fire && (cmd == CMD_SPIN) && !spin_err;
			end
			ST_COMMIT: begin
				spin_we = acc_q;
				spin_wa = QW'(fq_q);
				spin_wd = !old_spin_q;
			end
			default: begin
			end
		endcase
	end

	// Memories.
	always_ff @(posedge clk) begin
		if (coup_we) begin
			coup_mem[CW'(coupling_slot)] <= '{qa: qubit_a, qb: qubit_b, w: weight};
		end
		coup_s1 <= coup_mem[CW'(k_q)];
	end

	always_ff @(posedge clk) begin
		if (spin_we) begin
			spin_mem[spin_wa] <= spin_wd;
		end
		spin_a_s2 <= spin_mem[spin_ra];
		spin_b_s2 <= spin_mem[QW'(coup_s1.qb)];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_INIT) begin
			exp_mem[XW'(ia_q)] <= rom_val;
		end
		exp_rd_q <= exp_mem[XW'(qt_q)];
	end

	// Sum pipeline payload.
	always_ff @(posedge clk) begin
		w_s2  <= coup_s1.w;
		fa_s2 <= (coup_s1.qa == fq_q);
		fb_s2 <= (coup_s1.qb == fq_q);
	end

	// Control and datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			init_temp_q <= INIT_TEMP_RST;
			cool_q      <= COOL_RST;
			flat_cool_q <= FLAT_COOL_RST;
			offset_q    <= OFFSET_RST;
			hidden_q    <= HIDDEN_RST;
			e_now_q     <= 18'(OFFSET_RST) + 18'(HIDDEN_RST);
			e_best_q    <= 18'(OFFSET_RST) + 18'(HIDDEN_RST);
			temp_q      <= INIT_TEMP_RST;
			r_q         <= 33'h1_0000_0000;
			ia_q        <= '0;
			k_q         <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
			err_q       <= 1'b0;
			acc_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= sum_issue;
			v_s2    <= v_s1;

			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_INIT_TEMP: init_temp_q <= cfg_data;
					REG_COOL:      cool_q      <= cfg_data;
					REG_FLAT_COOL: flat_cool_q <= cfg_data;
					REG_OFFSET:    offset_q    <= cfg_data[13:0];
					REG_HIDDEN:    hidden_q    <= cfg_data[13:0];
					default: begin
					end
				endcase
			end

			if (out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;

			unique case (state_q)
				ST_INIT: begin
					r_q  <= r_prod[64:32];
					ia_q <= ia_q + 1'b1;
				end
				ST_IDLE: begin
					if (in_fire) begin
						acc_q <= 1'b0;
						fq_q  <= flip_qubit;
						uni_q <= uniform;
						k_q   <= '0;
						sum_q <= AW'(offset_q);
						unique case (cmd)
							CMD_LOAD:  err_q <= load_err;
							CMD_SPIN:  err_q <= spin_err;
							CMD_START: begin
								err_q    <= 1'b0;
								e_now_q  <= 18'(hidden_q) + 18'(offset_q);
								e_best_q <= 18'(hidden_q) + 18'(offset_q);
								temp_q   <= init_temp_q;
							end
							CMD_STEP:  err_q <= step_err;
							default:   err_q <= 1'b0;
						endcase
					end
				end
				ST_SUM: begin
					if (k_q == '0) old_spin_q <= spin_a_s2;
					if (sum_issue) k_q <= k_q + 1'b1;
					if (v_s2) begin
						// The proposed flip is applied on the fly to both ends.
						if ((spin_a_s2 ^ fa_s2) == (spin_b_s2 ^ fb_s2)) begin
							sum_q <= sum_q - AW'(w_s2);
						end else begin
							sum_q <= sum_q + AW'(w_s2);
						end
					end
				end
				ST_EVAL: begin
					hnew_q <= hnew_c;
					dh_q   <= dh_c;
				end
				ST_MUL: begin
					den_q  <= e_now_q[16:0] * temp_q;
					flat_q <= (dh_q == 0);
					if (dh_q < 0 || e_now_q <= 0) acc_q <= 1'b1;
				end
				ST_DIVSET: begin
					sat_q  <= (den_q == '0);
					rem_q  <= RW'({dh_q[17:0], 40'd0});
					dsh_q  <= RW'({den_q, QB'(0)});
					qt_q   <= '0;
					dcnt_q <= ($clog2(QB+1))'(QB);
				end
				ST_DIV: begin
					if (dcnt_q == ($clog2(QB+1))'(QB)) begin
						// Quotient at or above 2^QB: beyond the table.
						sat_q <= ge;
					end else begin
						if (ge) rem_q <= rem_q - dsh_q;
						qt_q <= {qt_q[QB-2:0], ge};
					end
					dsh_q  <= dsh_q >> 1;
					dcnt_q <= dcnt_q - 1'b1;
				end
				ST_ROM: begin
					if (!qfit) sat_q <= 1'b1;
				end
				ST_DECIDE: begin
					acc_q <= (thr > uni_q);
				end
				ST_COOL: begin
					temp_q <= cool_prod[63:32];
				end
				ST_COMMIT: begin
					if (acc_q) begin
						e_now_q <= hnew_q;
						if (hnew_q < e_best_q) e_best_q <= hnew_q;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						acc_out_q   <= acc_q;
						err_out_q   <= err_q;
						cur_out_q   <= e_now_q;
						best_out_q  <= e_best_q;
						temp_out_q  <= temp_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign accepted       = acc_out_q;
	assign range_error    = err_out_q;
	assign current_energy = cur_out_q;
	assign best_energy    = best_out_q;
	assign temperature    = temp_out_q;

	`ISA_ASSERT_IMP(a_best_le_now, out_valid, best_energy <= current_energy, "best energy above current energy")
	`ISA_ASSERT_IMP(a_acc_no_err, out_valid, !(accepted && range_error), "flip kept on a range error")
	`ISA_ASSERT_NXT(a_temp_src, state_q != ST_COOL && !(in_fire && cmd == CMD_START), $stable(temp_q), "temperature moved outside cooling or start")

endmodule

// File: dv/tb_ising_spin_annealing_step.sv
`timescale 1ns / 1ps
module tb_ising_spin_annealing_step;
	import isa_pkg::*;

	// The run is bounded well above its expected length: the table build after reset,
	// about 1250 beats of which roughly 550 are anneal steps, and receiver stalls on top
	// of that.
	localparam int CYCLE_LIMIT = 3000000;
	localparam int ROM_DEPTH   = 4096;

	typedef struct {
		logic        accepted;
		logic [17:0] current_energy;
		logic [17:0] best_energy;
		logic [31:0] temperature;
		logic        range_error;
	} anneal_result_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         cmd;
	logic [7:0]         coupling_slot;
	logic [6:0]         qubit_a;
	logic [6:0]         qubit_b;
	logic signed [7:0]  weight;
	logic               spin_up;
	logic [6:0]         flip_qubit;
	logic [15:0]        uniform;
	logic               out_valid;
	logic               out_stall;
	logic               accepted;
	logic signed [17:0] current_energy;
	logic signed [17:0] best_energy;
	logic [31:0]        temperature;
	logic               range_error;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [2:0]         cfg_index;
	logic [31:0]        cfg_data;

	ising_spin_annealing_step dut (.*);

	// Shadow copy of the block's registers and stores, kept by the predictor.
	logic [31:0]       shadow_init_temp;
	logic [31:0]       shadow_cool;
	logic [31:0]       shadow_flat_cool;
	logic [13:0]       shadow_offset;
	logic [13:0]       shadow_hidden;
	logic [127:0]      shadow_spins;
	logic [6:0]        shadow_qa [256];
	logic [6:0]        shadow_qb [256];
	logic signed [7:0] shadow_w [256];
	int                shadow_energy;
	int                shadow_best;
	logic [31:0]       shadow_temp;
	logic [15:0]       exp_rom [ROM_DEPTH];

	anneal_result_t pending_results[$];
	int             mismatches;
	int             results_seen;
	int             steps_sent;
	int             steps_kept;
	longint         cycles;
	int             burst_left;
	int             gap_max;
	int             stall_pct;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results still expected.", cycles,
				pending_results.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	// The receiver stalls on its own pattern; the density changes from phase to phase.
	always @(negedge clk) begin
		out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
	end

	function automatic void build_exp_rom();
		longint unsigned r;
		longint unsigned v;
		r = 64'd1 << 32;
		for (int k = 0; k < ROM_DEPTH; k++) begin
			v = (r + 64'd32768) >> 16;
			exp_rom[k] = (v > 64'd65535) ? 16'hFFFF : v[15:0];
			r = (r * 64'd4278222805) >> 32;
		end
	endfunction

	function automatic logic [31:0] scale_temp(logic [31:0] t, logic [31:0] f);
		logic [63:0] p;
		p = {32'd0, t} * {32'd0, f};
		return p[63:32];
	endfunction

	// Energy of the whole spin configuration, saturated to 18 signed bits.
	function automatic int ising_energy();
		int h;
		int sa;
		int sb;
		h = int'(shadow_offset);
		for (int k = 0; k < 256; k++) begin
			sa = shadow_spins[shadow_qa[k]] ? 1 : -1;
			sb = shadow_spins[shadow_qb[k]] ? 1 : -1;
			h -= int'(shadow_w[k]) * sa * sb;
		end
		if (h > E_MAX_I) h = E_MAX_I;
		if (h < E_MIN_I) h = E_MIN_I;
		return h;
	endfunction

	// Applies one accepted beat to the shadow state and queues the result it causes.
	function automatic void anneal_predict(cmd_e_t c, logic [7:0] slot, logic [6:0] qa,
			logic [6:0] qb, logic signed [7:0] w, logic up, logic [6:0] fq,
			logic [15:0] uni);
		anneal_result_t r;
		int             e_new;
		int             dh;
		logic [63:0]    num;
		logic [63:0]    den;
		logic [63:0]    q;
		logic [15:0]    thr;
		logic           keep;
		keep = 1'b0;
		case (c)
			CMD_LOAD: begin
				shadow_qa[slot] = qa;
				shadow_qb[slot] = qb;
				shadow_w[slot]  = w;
			end
			CMD_SPIN: begin
				shadow_spins[qa] = up;
			end
			CMD_START: begin
				shadow_energy = int'(shadow_hidden) + int'(shadow_offset);
				shadow_best   = shadow_energy;
				shadow_temp   = shadow_init_temp;
			end
			default: begin
				shadow_spins[fq] = ~shadow_spins[fq];
				e_new = ising_energy();
				dh = e_new - shadow_energy;
				if (dh < 0) begin
					keep = 1'b1;
					shadow_temp = scale_temp(shadow_temp, shadow_cool);
				end else begin
					if (shadow_energy <= 0) begin
						keep = 1'b1;
					end else begin
						num = 64'(dh) << 40;
						den = 64'(shadow_energy) * {32'd0, shadow_temp};
						q = ROM_DEPTH;
						if (den != 0) begin
							q = num / den;
							if (q > ROM_DEPTH) q = ROM_DEPTH;
						end
						thr = (q < ROM_DEPTH) ? exp_rom[q] : 16'd0;
						keep = thr > uni;
					end
					if (keep && dh == 0) shadow_temp = scale_temp(shadow_temp, shadow_flat_cool);
				end
				if (keep) shadow_energy = e_new;
				else shadow_spins[fq] = ~shadow_spins[fq];
				if (shadow_energy < shadow_best) shadow_best = shadow_energy;
				if (keep) steps_kept++;
			end
		endcase
		r.accepted       = keep;
		r.current_energy = shadow_energy[17:0];
		r.best_energy    = shadow_best[17:0];
		r.temperature    = shadow_temp;
		r.range_error    = 1'b0;
		pending_results.push_back(r);
	endfunction

	// Every result beat is checked against the oldest expectation.
	always @(posedge clk) begin
		anneal_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Result beat with nothing expected at %0t.", $realtime);
			end else begin
				e = pending_results.pop_front();
				if (accepted !== e.accepted || current_energy !== e.current_energy ||
						best_energy !== e.best_energy || temperature !== e.temperature ||
						range_error !== e.range_error) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("Mismatch at %0t: expected acc %0b E %0d best %0d T %0h err %0b,",
							$realtime, e.accepted, $signed(e.current_energy),
							$signed(e.best_energy), e.temperature, e.range_error);
						$display("  got acc %0b E %0d best %0d T %0h err %0b",
							accepted, current_energy, best_energy, temperature, range_error);
					end
				end
			end
		end
	end

	// Sends one input beat, inserting a random gap whenever a burst runs out and gap_max is nonzero.
	task automatic send_beat(input cmd_e_t c, input logic [7:0] slot, input logic [6:0] qa,
			input logic [6:0] qb, input logic signed [7:0] w, input logic up,
			input logic [6:0] fq, input logic [15:0] uni);
		int gap;
		begin
			@(negedge clk);
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 12);
				if (gap_max > 0) begin
					gap = $urandom_range(1, gap_max);
					in_valid <= 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
			burst_left--;
			cmd           <= c;
			coupling_slot <= slot;
			qubit_a       <= qa;
			qubit_b       <= qb;
			weight        <= w;
			spin_up       <= up;
			flip_qubit    <= fq;
			uniform       <= uni;
			in_valid      <= 1'b1;
			do @(posedge clk); while (in_stall);
			if (c == CMD_STEP) steps_sent++;
			anneal_predict(c, slot, qa, qb, w, up, fq, uni);
		end
	endtask

	task automatic park_sender();
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
	endtask

	// Sender pauses until every expected result has come back.
	task automatic drain_results();
		park_sender();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_INIT_TEMP: shadow_init_temp = data;
			REG_COOL:      shadow_cool      = data;
			REG_FLAT_COOL: shadow_flat_cool = data;
			REG_OFFSET:    shadow_offset    = data[13:0];
			default:       shadow_hidden    = data[13:0];
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic configure(input logic [31:0] t0, input logic [31:0] cf, input logic [31:0] ff,
			input logic [13:0] off, input logic [13:0] hid);
		write_reg(REG_INIT_TEMP, t0);
		write_reg(REG_COOL, cf);
		write_reg(REG_FLAT_COOL, ff);
		write_reg(REG_OFFSET, {18'd0, off});
		write_reg(REG_HIDDEN, {18'd0, hid});
	endtask

	// Fills every spin and every coupling so that no anneal step reads an unwritten
	// entry. Qubits 126 and 127 only ever couple to themselves here, so flipping them
	// gives a flat move until random loads touch them.
	task automatic test_fill_stores();
		logic signed [7:0] w;
		for (int i = 0; i < 128; i++) send_beat(CMD_SPIN, 8'd0, 7'(i), 7'd0, 8'sd0,
			1'($urandom_range(1)), 7'd0, 16'd0);
		for (int k = 0; k < 254; k++) begin
			w = $signed(8'($urandom_range(255)));
			if (k == 0) w = -8'sd128;
			if (k == 1) w = 8'sd127;
			send_beat(CMD_LOAD, 8'(k), 7'($urandom_range(125)), 7'($urandom_range(125)),
				w >>> 3, 1'b0, 7'd0, 16'd0);
		end
		send_beat(CMD_LOAD, 8'd254, 7'd126, 7'd126, -8'sd128, 1'b0, 7'd0, 16'd0);
		send_beat(CMD_LOAD, 8'd255, 7'd127, 7'd127, 8'sd127, 1'b1, 7'd0, 16'd0);
	endtask

	// Directed cases: starts, flat moves on the self-coupled qubits, extreme uniform
	// samples, non-positive energy and a zero temperature.
	task automatic test_directed();
		send_beat(CMD_START, 8'd0, 7'd0, 7'd0, 8'sd0, 1'b0, 7'd0, 16'd0);
		send_beat(CMD_STEP, 8'd0, 7'd0, 7'd0, 8'sd0, 1'b0, 7'd127, 16'd0);
		send_beat(CMD_STEP, 8'd0, 7'd0, 7'd0, 8'sd0, 1'b0, 7'd126, 16'hFFFF);
		send_beat(CMD_STEP, 8'd0, 7'd0, 7'd0, 8'sd0, 1'b0, 7'd0, 16'd0);
		send_beat(CMD_STEP, 8'd0, 7'd0, 7'd0, 8'sd0, 1'b0, 7'd0, 16'hFFFF);
		send_beat(CMD_SPIN, 8'd0, 7'd127, 7'd0, 8'sd0, 1'b1, 7'd0, 16'd0);
		send_beat(CMD_SPIN, 8'd0, 7'd0, 7'd0, 8'sd0, 1'b0, 7'd0, 16'd0);
		drain_results();
		// Zero offset and hidden energy: the run starts at energy zero, so the first move is kept.
		configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 14'd0, 14'd0);
		send_beat(CMD_START, 8'd0, 7'd0, 7'd0, 8'sd0, 1'b0, 7'd0, 16'd0);
		for (int i = 0; i < 4; i++) send_beat(CMD_STEP, 8'd0, 7'd0, 7'd0, 8'sd0, 1'b0,
			7'(i * 37), 16'hFFFF);
		send_beat(CMD_STEP, 8'd0, 7'd0, 7'd0, 8'sd0, 1'b0, 7'd127, 16'hFFFF);
		drain_results();
		// Zero temperature: the divisor is zero and uphill moves are always refused.
		configure(32'd0, 32'd0, 32'd0, 14'h3FFF, 14'h3FFF);
		send_beat(CMD_START, 8'd0, 7'd0, 7'd0, 8'sd0, 1'b0, 7'd0, 16'd0);
		for (int i = 0; i < 4; i++) send_beat(CMD_STEP, 8'd0, 7'd0, 7'd0, 8'sd0, 1'b0,
			7'($urandom_range(127)), 16'd0);
		drain_results();
	endtask

	task automatic random_beat(input int wshift);
		int                pick;
		logic [15:0]       uni;
		logic signed [7:0] w;
		pick = $urandom_range(99);
		uni = 16'($urandom_range(65535));
		if (pick % 7 == 0) uni = 16'd0;
		if (pick % 11 == 0) uni = 16'hFFFF;
		w = $signed(8'($urandom_range(255))) >>> wshift;
		if (pick < 62)
			send_beat(CMD_STEP, 8'($urandom_range(255)), 7'($urandom_range(127)),
				7'($urandom_range(127)), w, 1'($urandom_range(1)),
				7'($urandom_range(127)), uni);
		else if (pick < 78)
			send_beat(CMD_SPIN, 8'($urandom_range(255)), 7'($urandom_range(127)),
				7'($urandom_range(127)), w, 1'($urandom_range(1)),
				7'($urandom_range(127)), uni);
		else if (pick < 95)
			send_beat(CMD_LOAD, 8'($urandom_range(255)), 7'($urandom_range(127)),
				7'($urandom_range(127)), w, 1'($urandom_range(1)),
				7'($urandom_range(127)), uni);
		else
			send_beat(CMD_START, 8'($urandom_range(255)), 7'($urandom_range(127)),
				7'($urandom_range(127)), w, 1'($urandom_range(1)),
				7'($urandom_range(127)), uni);
	endtask

	// One random phase: a setting, a start, then random beats. Halfway through, the
	// sender waits for every outstanding result before carrying on.
	task automatic test_random_phase(input logic [31:0] t0, input logic [31:0] cf,
			input logic [31:0] ff, input logic [13:0] off, input logic [13:0] hid,
			input int beats, input int wshift);
		drain_results();
		configure(t0, cf, ff, off, hid);
		send_beat(CMD_START, 8'd0, 7'd0, 7'd0, 8'sd0, 1'b0, 7'd0, 16'd0);
		for (int i = 0; i < beats; i++) begin
			if (i == beats / 2) drain_results();
			random_beat(wshift);
		end
	endtask

	initial begin
		cycles = 0;
		mismatches = 0;
		results_seen = 0;
		steps_sent = 0;
		steps_kept = 0;
		burst_left = 0;
		gap_max = 0;
		stall_pct = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		cmd = CMD_LOAD;
		coupling_slot = '0;
		qubit_a = '0;
		qubit_b = '0;
		weight = '0;
		spin_up = 1'b0;
		flip_qubit = '0;
		uniform = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_INIT_TEMP;
		cfg_data = '0;
		shadow_init_temp = INIT_TEMP_RST;
		shadow_cool = COOL_RST;
		shadow_flat_cool = FLAT_COOL_RST;
		shadow_offset = OFFSET_RST;
		shadow_hidden = HIDDEN_RST;
		shadow_spins = '0;
		shadow_energy = int'(HIDDEN_RST) + int'(OFFSET_RST);
		shadow_best = shadow_energy;
		shadow_temp = INIT_TEMP_RST;
		build_exp_rom();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		gap_max = 3;
		stall_pct = 20;
		test_fill_stores();
		test_directed();

		// Random phases, from defaults to extremes, with varying idling on both sides.
		gap_max = 0;
		stall_pct = 0;
		test_random_phase(INIT_TEMP_RST, COOL_RST, FLAT_COOL_RST, OFFSET_RST, HIDDEN_RST,
			170, 3);
		gap_max = 6;
		stall_pct = 40;
		test_random_phase(32'hFFFF_FFFF, 32'hF000_0000, 32'hFFFF_FFFF, 14'd200, 14'd100,
			170, 4);
		gap_max = 2;
		stall_pct = 70;
		test_random_phase(32'h4000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 14'h3FFF, 14'h3FFF,
			170, 2);
		gap_max = 10;
		stall_pct = 10;
		test_random_phase(32'h0100_0000, 32'h0000_0001, 32'hFFFF_0000, 14'd0, 14'd50,
			170, 0);
		gap_max = 4;
		stall_pct = 30;
		test_random_phase(32'h8000_0000, 32'hFFFE_0000, 32'd0, 14'd600, 14'd0, 170, 5);

		drain_results();
		repeat (400) @(posedge clk);
		if (pending_results.size() != 0) mismatches++;
		$display("Covered %0d result beats, %0d anneal steps of which %0d were kept,",
			results_seen, steps_sent, steps_kept);
		$display("over several register settings with sender gaps and receiver stalls.");
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches.", mismatches);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// File: files.f
+incdir+rtl
rtl/isa_pkg.sv
rtl/ising_spin_annealing_step.sv
dv/tb_ising_spin_annealing_step.sv
